// File: src/tse_pkg.sv
// Shared types, constants and helpers for the torus surface evaluator.
package tse_pkg;

  localparam int AngleBits = 16;
  localparam int TrigFracBits = 15;
  localparam int CordicSteps = TrigFracBits + 1;
  localparam int CompW = 34;
  localparam int TrigW = TrigFracBits + 3;
  localparam int ZW = 32;
  localparam int RegW = 16;

  // CORDIC start value: round(K * 2^F)
  localparam longint GainQ32 = 64'd2608131496;
  localparam longint XInit = (GainQ32 + (64'sd1 <<< (31 - TrigFracBits))) >>> (32 - TrigFracBits);

  localparam logic [RegW-1:0] MajorReset = 16'd512;
  localparam logic [RegW-1:0] MinorReset = 16'd256;

  typedef enum logic [0:0] {
    CFG_MAJOR = 1'b0,
    CFG_MINOR = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    VK_POS = 3'd0,
    VK_DU  = 3'd1,
    VK_DV  = 3'd2,
    VK_NRM = 3'd3,
    VK_DUU = 3'd4,
    VK_DUV = 3'd5,
    VK_DVV = 3'd6
  } vkind_e;

  typedef logic signed [TrigW-1:0] trig_t;
  typedef logic signed [CompW-1:0] comp_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic signed [ZW-1:0] atan_tab(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0: t = 32'sd536870912;  1: t = 32'sd316933406;  2: t = 32'sd167458907;
      3: t = 32'sd85004756;   4: t = 32'sd42667331;   5: t = 32'sd21354465;
      6: t = 32'sd10679838;   7: t = 32'sd5340245;    8: t = 32'sd2670163;
      9: t = 32'sd1335087;    10: t = 32'sd667544;    11: t = 32'sd333772;
      12: t = 32'sd166886;    13: t = 32'sd83443;     14: t = 32'sd41722;
      15: t = 32'sd20861;     16: t = 32'sd10430;     17: t = 32'sd5215;
      18: t = 32'sd2608;      19: t = 32'sd1304;      20: t = 32'sd652;
      21: t = 32'sd326;       22: t = 32'sd163;       23: t = 32'sd81;
      24: t = 32'sd41;        25: t = 32'sd20;        26: t = 32'sd10;
      27: t = 32'sd5;         28: t = 32'sd3;         29: t = 32'sd1;
      30: t = 32'sd1;         default: t = 32'sd0;
    endcase
    return t;
  endfunction

  // Round a 64-bit product right by TrigFracBits, half up.
  function automatic comp_t rnd_f(input logic signed [63:0] a);
    logic signed [63:0] t;
    t = (a + (64'sd1 <<< (TrigFracBits - 1))) >>> TrigFracBits;
    return t[CompW-1:0];
  endfunction

  // Round a 64-bit product right by eight bits, half up.
  function automatic comp_t rnd_8(input logic signed [63:0] a);
    logic signed [63:0] t;
    t = (a + 64'sd128) >>> 8;
    return t[CompW-1:0];
  endfunction

endpackage

// File: src/tse_cordic.sv
// Pipelined sine/cosine CORDIC: one rotation step per register stage.
module tse_cordic (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [tse_pkg::AngleBits-1:0]    angle_i,
  output tse_pkg::trig_t                   cos_o,
  output tse_pkg::trig_t                   sin_o
);
  localparam int N = tse_pkg::CordicSteps;
  localparam int W = tse_pkg::TrigW;

  logic signed [W-1:0]           x_q [N+1];
  logic signed [W-1:0]           y_q [N+1];
  logic signed [tse_pkg::ZW-1:0] z_q [N+1];
  logic [1:0]                    quad_q [N+1];
  logic [31:0]                   ph;

  assign ph = {angle_i, {(32 - tse_pkg::AngleBits){1'b0}}};

  // Load the first stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= W'(tse_pkg::XInit);
      y_q[0]    <= '0;
      z_q[0]    <= {2'b00, ph[29:0]};
      quad_q[0] <= ph[31:30];
    end
  end

  // Rotate one step per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quad_q[i+1] <= quad_q[i];
        if (!z_q[i][tse_pkg::ZW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - tse_pkg::atan_tab(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + tse_pkg::atan_tab(i);
        end
      end
    end
  end

  logic signed [W-1:0] c, s;
  localparam logic signed [W-1:0] One = W'(1 << tse_pkg::TrigFracBits);

  // Map to quadrant and clamp
  always_comb begin
    case (quad_q[N])
      2'd0:    begin c = x_q[N];  s = y_q[N];  end
      2'd1:    begin c = -y_q[N]; s = x_q[N];  end
      2'd2:    begin c = -x_q[N]; s = -y_q[N]; end
      default: begin c = y_q[N];  s = -x_q[N]; end
    endcase
    cos_o = (c > One) ? One : ((c < -One) ? -One : c);
    sin_o = (s > One) ? One : ((s < -One) ? -One : s);
  end

endmodule

// File: src/tse_geom.sv
// Geometry pipeline: radii products, position, normal and derivative terms.
module tse_geom (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [tse_pkg::RegW-1:0]   major_i,
  input  logic [tse_pkg::RegW-1:0]   minor_i,
  input  tse_pkg::trig_t             cu_i,
  input  tse_pkg::trig_t             su_i,
  input  tse_pkg::trig_t             cv_i,
  input  tse_pkg::trig_t             sv_i,
  output tse_pkg::comp_t             px_o,
  output tse_pkg::comp_t             py_o,
  output tse_pkg::comp_t             rc_o,
  output tse_pkg::comp_t             rs_o,
  output tse_pkg::comp_t             nx_o,
  output tse_pkg::comp_t             ny_o,
  output tse_pkg::comp_t             nz_o,
  output tse_pkg::comp_t             rscu_o,
  output tse_pkg::comp_t             rssu_o,
  output tse_pkg::comp_t             rccu_o,
  output tse_pkg::comp_t             rcsu_o
);
  typedef logic signed [63:0] w_t;

  // Stage A: r*cos v, r*sin v
  tse_pkg::comp_t rc_a_q, rs_a_q, w_a_q;
  tse_pkg::trig_t cu_a_q, su_a_q;
  tse_pkg::comp_t rc_t, rs_t;
  assign rc_t = tse_pkg::rnd_f(w_t'($signed({1'b0, minor_i})) * w_t'(cv_i));
  assign rs_t = tse_pkg::rnd_f(w_t'($signed({1'b0, minor_i})) * w_t'(sv_i));
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rc_a_q <= rc_t;
      rs_a_q <= rs_t;
      w_a_q  <= tse_pkg::CompW'($signed({1'b0, major_i})) + rc_t;
      cu_a_q <= cu_i;
      su_a_q <= su_i;
    end
  end

  // Stage B: products with cos u and sin u
  tse_pkg::comp_t px_b_q, py_b_q, rc_b_q, rs_b_q, nz_b_q;
  tse_pkg::comp_t rscu_b_q, rssu_b_q, rccu_b_q, rcsu_b_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_b_q   <= tse_pkg::rnd_f(w_t'(w_a_q) * w_t'(cu_a_q));
      py_b_q   <= tse_pkg::rnd_f(w_t'(w_a_q) * w_t'(su_a_q));
      rscu_b_q <= tse_pkg::rnd_f(w_t'(rs_a_q) * w_t'(cu_a_q));
      rssu_b_q <= tse_pkg::rnd_f(w_t'(rs_a_q) * w_t'(su_a_q));
      rccu_b_q <= tse_pkg::rnd_f(w_t'(rc_a_q) * w_t'(cu_a_q));
      rcsu_b_q <= tse_pkg::rnd_f(w_t'(rc_a_q) * w_t'(su_a_q));
      nz_b_q   <= tse_pkg::rnd_8(w_t'(w_a_q) * w_t'(rs_a_q));
      rc_b_q   <= rc_a_q;
      rs_b_q   <= rs_a_q;
    end
  end

  // Stage C: normal x and y
  // Other terms are ready one stage earlier; line them up here
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_o   <= tse_pkg::rnd_8(w_t'(px_b_q) * w_t'(rc_b_q));
      ny_o   <= tse_pkg::rnd_8(w_t'(py_b_q) * w_t'(rc_b_q));
      px_o   <= px_b_q;
      py_o   <= py_b_q;
      rc_o   <= rc_b_q;
      rs_o   <= rs_b_q;
      nz_o   <= nz_b_q;
      rscu_o <= rscu_b_q;
      rssu_o <= rssu_b_q;
      rccu_o <= rccu_b_q;
      rcsu_o <= rcsu_b_q;
    end
  end

endmodule

// File: src/torus_surface_evaluator_top.sv
// Top level of the torus surface evaluator: pipeline, result buffer, sequencer.
//
// Input channel: angle_u_i, angle_v_i, end_of_batch_i transfer on in_valid_i &&
// in_ready_o. Each point yields seven result transfers on out_valid_o &&
// out_ready_i in kind order: position, d/du, d/dv, normal, d2/du2, d2/dudv,
// d2/dv2; last_vector_o marks the seventh and batch_done_o copies
// end_of_batch there.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 major radius,
// 1 minor radius, Q8.8); other indices are dropped. Write only while idle.
// Path from input transfer to the first result: 17 CORDIC stages, 3 geometry
// stages, 1 output register.
// The single result channel sets the point rate: seven transfers per point.
// The pipeline advances only when its tail slot is free, so a receiver stall
// freezes it with nothing lost; a new point can enter while the previous
// one is still being serialised.
// Reset: radii return to 2.0 and 1.0, the pipeline and buffer empty.
module torus_surface_evaluator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] angle_u_i,
  input  logic [15:0] angle_v_i,
  input  logic        end_of_batch_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  vector_kind_o,
  output logic signed [33:0] comp_x_o,
  output logic signed [33:0] comp_y_o,
  output logic signed [33:0] comp_z_o,
  output logic        last_vector_o,
  output logic        batch_done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  localparam int Depth = tse_pkg::CordicSteps + 1 + 3;

  logic [tse_pkg::RegW-1:0] major_q, minor_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_q <= tse_pkg::MajorReset;
      minor_q <= tse_pkg::MinorReset;
    end else if (cfg_valid_i) begin
      case (tse_pkg::cfg_idx_e'(cfg_index_i))
        tse_pkg::CFG_MAJOR: major_q <= cfg_data_i;
        tse_pkg::CFG_MINOR: minor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control: valid and batch flag travel alongside
  logic [Depth-1:0] vld_q, eob_q;
  logic             buf_full_q, load_buf, en;
  logic [2:0]       kind_q;
  logic             last;
  // Refill the buffer in the same cycle as its last vector leaves
  assign load_buf = vld_q[Depth-1] && (!buf_full_q || (last && out_ready_i));
  assign en = !vld_q[Depth-1] || load_buf;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) eob_q <= {eob_q[Depth-2:0], end_of_batch_i};
  end

  tse_pkg::trig_t cu, su, cv, sv;
  tse_cordic u_cu (.clk_i, .en_i(en), .angle_i(angle_u_i), .cos_o(cu), .sin_o(su));
  tse_cordic u_cv (.clk_i, .en_i(en), .angle_i(angle_v_i), .cos_o(cv), .sin_o(sv));

  tse_pkg::comp_t px, py, rc, rs, nx, ny, nz, rscu, rssu, rccu, rcsu;
  tse_geom u_geom (
    .clk_i, .en_i(en), .major_i(major_q), .minor_i(minor_q),
    .cu_i(cu), .su_i(su), .cv_i(cv), .sv_i(sv),
    .px_o(px), .py_o(py), .rc_o(rc), .rs_o(rs), .nx_o(nx), .ny_o(ny), .nz_o(nz),
    .rscu_o(rscu), .rssu_o(rssu), .rccu_o(rccu), .rcsu_o(rcsu)
  );

  // Result buffer: hold one point's terms while its seven vectors go out
  tse_pkg::comp_t b_px_q, b_py_q, b_rc_q, b_rs_q, b_nx_q, b_ny_q, b_nz_q;
  tse_pkg::comp_t b_rscu_q, b_rssu_q, b_rccu_q, b_rcsu_q;
  logic           b_eob_q;
  assign last = (kind_q == tse_pkg::VK_DVV);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_full_q <= 1'b0;
      kind_q     <= tse_pkg::VK_POS;
    end else if (load_buf) begin
      buf_full_q <= 1'b1;
      kind_q     <= tse_pkg::VK_POS;
    end else if (buf_full_q && out_ready_i) begin
      kind_q     <= last ? tse_pkg::VK_POS : kind_q + 3'd1;
      buf_full_q <= !last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_buf) begin
      b_px_q <= px; b_py_q <= py; b_rc_q <= rc; b_rs_q <= rs;
      b_nx_q <= nx; b_ny_q <= ny; b_nz_q <= nz;
      b_rscu_q <= rscu; b_rssu_q <= rssu; b_rccu_q <= rccu; b_rcsu_q <= rcsu;
      b_eob_q <= eob_q[Depth-1];
    end
  end

  // Select the vector for the current kind
  always_comb begin
    case (tse_pkg::vkind_e'(kind_q))
      tse_pkg::VK_POS: begin comp_x_o = b_px_q; comp_y_o = b_py_q; comp_z_o = b_rs_q; end
      tse_pkg::VK_DU:  begin comp_x_o = -b_py_q; comp_y_o = b_px_q; comp_z_o = '0; end
      tse_pkg::VK_DV:  begin comp_x_o = -b_rscu_q; comp_y_o = -b_rssu_q; comp_z_o = b_rc_q; end
      tse_pkg::VK_NRM: begin comp_x_o = b_nx_q; comp_y_o = b_ny_q; comp_z_o = b_nz_q; end
      tse_pkg::VK_DUU: begin comp_x_o = -b_px_q; comp_y_o = -b_py_q; comp_z_o = '0; end
      tse_pkg::VK_DUV: begin comp_x_o = b_rssu_q; comp_y_o = -b_rscu_q; comp_z_o = '0; end
      tse_pkg::VK_DVV: begin comp_x_o = -b_rccu_q; comp_y_o = -b_rcsu_q; comp_z_o = -b_rs_q; end
      default:         begin comp_x_o = '0; comp_y_o = '0; comp_z_o = '0; end
    endcase
  end

  assign out_valid_o   = buf_full_q;
  assign vector_kind_o = kind_q;
  assign last_vector_o = last;
  assign batch_done_o  = last && b_eob_q;

`ifndef SYNTH
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kind_q <= tse_pkg::VK_DVV) else $error("vector kind out of range");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (buf_full_q && load_buf) |-> (last && out_ready_i)) else $error("buffer overwritten");
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(kind_q)) else $error("kind moved on stall");
  a_tail_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[Depth-1] && buf_full_q && !(last && out_ready_i)) |-> !in_ready_o)
    else $error("pipe advanced while full");
`endif

endmodule

// File: test/torus_surface_evaluator_top_tb.sv
// Testbench for the torus surface evaluator: random angles and radii against an in-bench predictor.
module torus_surface_evaluator_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               last;
    logic               done;
  } vec_t;

  // Torus geometry predictor with its own copy of the radii
  class torus_board;
    logic [15:0] ring_r;
    logic [15:0] tube_r;
    vec_t        pending[$];
    int          errors;

    function new();
      ring_r = 16'd512;
      tube_r = 16'd256;
      errors = 0;
    endfunction

    static function longint shr(longint a, int s);
      return a >>> s;
    endfunction

    static function longint rq(longint a, int s);
      return (a + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    static function longint atan_turn(int i);
      longint t[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                        21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                        333772, 166886, 83443, 41722, 20861};
      return t[i];
    endfunction

    // CORDIC sine and cosine of a 16-bit phase
    static function void trig(logic [15:0] ang, output longint c, output longint s);
      logic [31:0] ph;
      longint x, y, z, xs, ys, one;
      ph = {ang, 16'd0};
      z = longint'(ph[29:0]);
      x = (64'sd2608131496 + (64'sd1 <<< 16)) >>> 17;
      y = 0;
      one = 64'sd1 <<< 15;
      for (int i = 0; i <= 15; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_turn(i);
        end else begin
          x += ys; y -= xs; z += atan_turn(i);
        end
      end
      case (ph[31:30])
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
      if (c > one) c = one;
      if (c < -one) c = -one;
      if (s > one) s = one;
      if (s < -one) s = -one;
    endfunction

    function void push(tse_pkg::vkind_e k, longint x, longint y, longint z, logic eob);
      vec_t v;
      v.kind = k;
      v.x = x[33:0];
      v.y = y[33:0];
      v.z = z[33:0];
      v.last = (k == tse_pkg::VK_DVV);
      v.done = (k == tse_pkg::VK_DVV) ? eob : 1'b0;
      pending.push_back(v);
    endfunction

    // Note an accepted point and queue its seven vectors
    function void note_point(logic [15:0] u, logic [15:0] v, logic eob);
      longint cu, su, cv, sv, rc, rs, w, px, py;
      trig(u, cu, su);
      trig(v, cv, sv);
      rc = rq(longint'(tube_r) * cv, 15);
      rs = rq(longint'(tube_r) * sv, 15);
      w = longint'(ring_r) + rc;
      px = rq(w * cu, 15);
      py = rq(w * su, 15);
      push(tse_pkg::VK_POS, px, py, rs, eob);
      push(tse_pkg::VK_DU, -py, px, 0, eob);
      push(tse_pkg::VK_DV, -rq(rs * cu, 15), -rq(rs * su, 15), rc, eob);
      push(tse_pkg::VK_NRM, rq(px * rc, 8), rq(py * rc, 8), rq(w * rs, 8), eob);
      push(tse_pkg::VK_DUU, -px, -py, 0, eob);
      push(tse_pkg::VK_DUV, rq(rs * su, 15), -rq(rs * cu, 15), 0, eob);
      push(tse_pkg::VK_DVV, -rq(rc * cu, 15), -rq(rc * su, 15), -rs, eob);
    endfunction

    // Compare one result transfer with the oldest expected vector
    function void check_vector(vec_t got);
      vec_t exp_v;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors++;
        return;
      end
      exp_v = pending.pop_front();
      if (got.kind != exp_v.kind) begin
        $display("%0t: kind exp %0d got %0d", $realtime, exp_v.kind, got.kind); errors++;
      end
      if (got.x != exp_v.x) begin
        $display("%0t: x exp %0d got %0d", $realtime, exp_v.x, got.x); errors++;
      end
      if (got.y != exp_v.y) begin
        $display("%0t: y exp %0d got %0d", $realtime, exp_v.y, got.y); errors++;
      end
      if (got.z != exp_v.z) begin
        $display("%0t: z exp %0d got %0d", $realtime, exp_v.z, got.z); errors++;
      end
      if (got.last != exp_v.last) begin
        $display("%0t: last exp %0b got %0b", $realtime, exp_v.last, got.last); errors++;
      end
      if (got.done != exp_v.done) begin
        $display("%0t: done exp %0b got %0b", $realtime, exp_v.done, got.done); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] angle_u_i = '0;
  logic [15:0] angle_v_i = '0;
  logic        end_of_batch_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  vector_kind_o;
  logic signed [33:0] comp_x_o, comp_y_o, comp_z_o;
  logic        last_vector_o;
  logic        batch_done_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  torus_board board = new();
  bit         sending_done = 1'b0;

  torus_surface_evaluator_top DUT (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Fixed ceiling on run time
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: random stalls, check on every transfer
  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      board.check_vector({vector_kind_o, comp_x_o, comp_y_o, comp_z_o,
                          last_vector_o, batch_done_o});
    end
  end

  // Send one point, after a random gap unless busy; valid stays up until the next gap
  task automatic send_point(logic [15:0] u, logic [15:0] v, logic eob, bit busy);
    int gap;
    gap = busy ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    angle_u_i <= u;
    angle_v_i <= v;
    end_of_batch_i <= eob;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_point(u, v, eob);
  endtask

  // Wait until the block holds no work, then write a radius
  task automatic write_radius(tse_pkg::cfg_idx_e idx, logic [15:0] val);
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == tse_pkg::CFG_MAJOR) board.ring_r = val;
    else board.tube_r = val;
  endtask

  task automatic random_points(int n);
    bit busy;
    for (int i = 0; i < n; i++) begin
      busy = (i % 40) < 12;
      send_point(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 1'($urandom_range(0, 1)), busy);
    end
  endtask

  initial begin
    logic [15:0] dir_ang[12] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000,
                                 16'h3FFF, 16'h2000, 16'h5555, 16'hAAAA, 16'h0001,
                                 16'h7FFF, 16'hE000};
    int cyc;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: quadrant edges and extremes at reset radii
    for (int i = 0; i < 12; i++)
      send_point(dir_ang[i], dir_ang[11 - i], i[0], 1'b0);
    // Zero ring radius and extreme radii
    write_radius(tse_pkg::CFG_MAJOR, 16'd0);
    write_radius(tse_pkg::CFG_MINOR, 16'hFFFF);
    for (int i = 0; i < 6; i++)
      send_point(dir_ang[i], dir_ang[2 * i], 1'b1, 1'b0);
    write_radius(tse_pkg::CFG_MAJOR, 16'hFFFF);
    send_point(16'h1234, 16'h0000, 1'b0, 1'b0);
    send_point(16'hFFFF, 16'h8000, 1'b1, 1'b0);

    // Random phases, several radius settings
    write_radius(tse_pkg::CFG_MINOR, 16'd0);
    random_points(40);
    write_radius(tse_pkg::CFG_MAJOR, 16'd512);
    write_radius(tse_pkg::CFG_MINOR, 16'd256);
    random_points(90);
    // Drain completely before resuming
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    random_points(40);
    write_radius(tse_pkg::CFG_MAJOR, 16'($urandom_range(0, 65535)));
    write_radius(tse_pkg::CFG_MINOR, 16'($urandom_range(0, 65535)));
    random_points(80);
    write_radius(tse_pkg::CFG_MAJOR, 16'd300);
    write_radius(tse_pkg::CFG_MINOR, 16'd900);
    random_points(80);

    // Drain, then allow for the pipeline tail
    in_valid_i <= 1'b0;
    cyc = 0;
    while (board.pending.size() != 0 && cyc < 100000) begin
      @(posedge clk_i);
      cyc++;
    end
    repeat (40) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
